>>> design/bcf_pkg.sv
`default_nettype none
package bcf_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int MAX_PIECES   = 1024;
    localparam int MAX_LISTS    = 16;
    localparam int HEADER_BYTES = 40;

    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 14;
    localparam int KIND_W     = 3;
    localparam int ALIGN_BITS = 4;

    localparam int BLK_IW = $clog2(MAX_BLOCKS);
    localparam int BLK_CW = $clog2(MAX_BLOCKS + 1);
    localparam int PC_IW  = $clog2(MAX_PIECES);
    localparam int PC_LW  = $clog2(MAX_PIECES + 1);
    localparam int LS_IW  = $clog2(MAX_LISTS);
    localparam int LS_CW  = $clog2(MAX_LISTS + 1);

    localparam int IN_RAW_W  = 5 * ADDR_W + SIZE_W;
    localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * ADDR_W;

    localparam logic [PC_LW-1:0] LINK_NONE = PC_LW'(MAX_PIECES);

    typedef enum logic [KIND_W-1:0] {
        REQ_LEND    = 3'd0,
        REQ_CARVE   = 3'd1,
        REQ_FILE    = 3'd2,
        REQ_REISSUE = 3'd3,
        REQ_RETURN  = 3'd4
    } req_kind_t;

    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_BLOCKS_FULL   = 4'd1,
        ST_BAD_HEADER    = 4'd2,
        ST_UNKNOWN_BLOCK = 4'd3,
        ST_BAD_SIZE      = 4'd4,
        ST_PIECES_FULL   = 4'd5,
        ST_UNKNOWN_NODE  = 4'd6,
        ST_ALREADY_FILED = 4'd7,
        ST_LISTS_FULL    = 4'd8,
        ST_LIST_EMPTY    = 4'd9
    } status_t;

    typedef struct packed {
        logic              alive;
        logic [ADDR_W-1:0] limit;
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] base;
    } blk_ent_t;

    typedef struct packed {
        logic              onlist;
        logic              alive;
        logic [PC_LW-1:0]  link;
        logic [BLK_IW-1:0] owner;
        logic [ADDR_W-1:0] addr;
    } pc_ent_t;

    typedef struct packed {
        logic [PC_LW-1:0]  head;
        logic [ADDR_W-1:0] addr;
    } ls_ent_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] new_free_start;
        logic [ADDR_W-1:0] owner_block_addr;
        logic [ADDR_W-1:0] result_addr;
    } result_t;

endpackage
`default_nettype wire

>>> design/block_carve_freelist_engine.sv
// lend checks the header; carve scans the block table for the block
// file scans the pieces and the list table, reissue the list table; a popped piece adds an owner lookup
// return scans the blocks, every carved piece, every list and every list node
// one request in flight; the next word is taken once the previous result is in the output register
// reset clears the fill counts and the sequencer; table contents need no clearing pass
`default_nettype none
module block_carve_freelist_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // block_addr, free_start, block_end, piece_size, list_addr, node_addr, zero pad
    input  wire logic [bcf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // req_type
    input  wire logic [bcf_pkg::KIND_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // result_addr, owner_block_addr, new_free_start
    output logic [bcf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic [3:0]                         m_axis_tuser
);
    import bcf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_BRD, S_BCK, S_CARVE1, S_CARVE2, S_PRD, S_PCK,
        S_LRD, S_LCK, S_LNEW, S_LDONE, S_RRD, S_RCK, S_ORD, S_OCK,
        S_KRD, S_KCK, S_KBLK, S_URD, S_UCK, S_WRD, S_WCK, S_DONE
    } state_t;

    state_t            state_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [ADDR_W-1:0] baddr_reg, favail_reg, bend_reg, laddr_reg, naddr_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [BLK_CW-1:0] blk_used_reg, bscan_reg;
    logic [PC_LW-1:0]  pc_used_reg, pscan_reg;
    logic [LS_CW-1:0]  ls_used_reg, lscan_reg;
    logic [BLK_IW-1:0] bidx_reg;
    logic [PC_IW-1:0]  pidx_reg, prev_idx_reg;
    logic [LS_IW-1:0]  lidx_reg;
    logic [PC_LW-1:0]  lhead_reg, cur_reg;
    logic              lnew_reg, prev_head_reg;
    logic [ADDR_W:0]   diff_reg;
    blk_ent_t          bent_reg;
    pc_ent_t           pent_reg, prev_ent_reg;
    ls_ent_t           lent_reg;
    result_t           res_reg;

    logic              blk_we_reg, pc_we_reg, ls_we_reg;
    logic [BLK_IW-1:0] blk_waddr_reg;
    logic [PC_IW-1:0]  pc_waddr_reg;
    logic [LS_IW-1:0]  ls_waddr_reg;
    blk_ent_t          blk_wdata_reg;
    pc_ent_t           pc_wdata_reg;
    ls_ent_t           ls_wdata_reg;

    blk_ent_t          blk_rdata;
    pc_ent_t           pc_rdata;
    ls_ent_t           ls_rdata;
    logic [BLK_IW-1:0] blk_raddr;
    logic [PC_IW-1:0]  pc_raddr;
    logic [LS_IW-1:0]  ls_raddr;

    logic              out_ready;
    logic [ADDR_W:0]   lend_sum;
    logic [ADDR_W-1:0] carve_next;
    logic              lscan_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign lend_sum      = {1'b0, baddr_reg} + (ADDR_W + 1)'(HEADER_BYTES);
    assign carve_next    = bent_reg.cursor + ADDR_W'(size_reg);
    assign lscan_last    = ((lscan_reg + LS_CW'(1)) == ls_used_reg);
    assign blk_raddr     = (state_reg == S_ORD) ? bidx_reg : bscan_reg[BLK_IW-1:0];
    assign ls_raddr      = lscan_reg[LS_IW-1:0];

    always_comb
    begin
        case (state_reg)
            S_RRD:   pc_raddr = lhead_reg[PC_IW-1:0];
            S_WRD:   pc_raddr = cur_reg[PC_IW-1:0];
            default: pc_raddr = pscan_reg[PC_IW-1:0];
        endcase
    end

    bcf_ram #(.WIDTH($bits(blk_ent_t)), .DEPTH(MAX_BLOCKS)) u_blk_ram (
        .clk   (clk),
        .we    (blk_we_reg),
        .waddr (blk_waddr_reg),
        .wdata (blk_wdata_reg),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    bcf_ram #(.WIDTH($bits(pc_ent_t)), .DEPTH(MAX_PIECES)) u_pc_ram (
        .clk   (clk),
        .we    (pc_we_reg),
        .waddr (pc_waddr_reg),
        .wdata (pc_wdata_reg),
        .raddr (pc_raddr),
        .rdata (pc_rdata)
    );

    bcf_ram #(.WIDTH($bits(ls_ent_t)), .DEPTH(MAX_LISTS)) u_ls_ram (
        .clk   (clk),
        .we    (ls_we_reg),
        .waddr (ls_waddr_reg),
        .wdata (ls_wdata_reg),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    bcf_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (state_reg == S_DONE),
        .in_ready      (out_ready),
        .in_res        (res_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            blk_used_reg <= '0;
            pc_used_reg  <= '0;
            ls_used_reg  <= '0;
            blk_we_reg   <= 1'b0;
            pc_we_reg    <= 1'b0;
            ls_we_reg    <= 1'b0;
        end
        else
        begin
            blk_we_reg <= 1'b0;
            pc_we_reg  <= 1'b0;
            ls_we_reg  <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        kind_reg   <= s_axis_tuser;
                        baddr_reg  <= s_axis_tdata[ADDR_W-1:0];
                        favail_reg <= s_axis_tdata[2*ADDR_W-1:ADDR_W];
                        bend_reg   <= s_axis_tdata[3*ADDR_W-1:2*ADDR_W];
                        size_reg   <= s_axis_tdata[3*ADDR_W+SIZE_W-1:3*ADDR_W];
                        laddr_reg  <= s_axis_tdata[4*ADDR_W+SIZE_W-1:3*ADDR_W+SIZE_W];
                        naddr_reg  <= s_axis_tdata[5*ADDR_W+SIZE_W-1:4*ADDR_W+SIZE_W];
                        res_reg    <= '0;
                        state_reg  <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    case (kind_reg)
                        REQ_LEND:
                        begin
                            state_reg <= S_DONE;
                            if (blk_used_reg >= BLK_CW'(MAX_BLOCKS))
                            begin
                                res_reg.status <= ST_BLOCKS_FULL;
                            end
                            else if (lend_sum != {1'b0, favail_reg} || bend_reg <= favail_reg)
                            begin
                                res_reg.status <= ST_BAD_HEADER;
                            end
                            else
                            begin
                                blk_we_reg           <= 1'b1;
                                blk_waddr_reg        <= blk_used_reg[BLK_IW-1:0];
                                blk_wdata_reg.alive  <= 1'b1;
                                blk_wdata_reg.limit  <= bend_reg;
                                blk_wdata_reg.cursor <= favail_reg;
                                blk_wdata_reg.base   <= baddr_reg;
                                blk_used_reg         <= blk_used_reg + BLK_CW'(1);
                                res_reg.result_addr  <= baddr_reg;
                            end
                        end
                        REQ_CARVE, REQ_RETURN:
                        begin
                            if (blk_used_reg == '0)
                            begin
                                res_reg.status <= ST_UNKNOWN_BLOCK;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                bscan_reg <= blk_used_reg - BLK_CW'(1);
                                state_reg <= S_BRD;
                            end
                        end
                        REQ_FILE:
                        begin
                            if (pc_used_reg == '0)
                            begin
                                res_reg.status <= ST_UNKNOWN_NODE;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                pscan_reg <= pc_used_reg - PC_LW'(1);
                                state_reg <= S_PRD;
                            end
                        end
                        REQ_REISSUE:
                        begin
                            lscan_reg <= '0;
                            state_reg <= (ls_used_reg == '0) ? S_LNEW : S_LRD;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_BRD:
                begin
                    state_reg <= S_BCK;
                end
                S_BCK:
                begin
                    if (blk_rdata.alive && blk_rdata.base == baddr_reg)
                    begin
                        bidx_reg  <= bscan_reg[BLK_IW-1:0];
                        bent_reg  <= blk_rdata;
                        pscan_reg <= '0;
                        if (kind_reg == REQ_CARVE)
                        begin
                            state_reg <= S_CARVE1;
                        end
                        else
                        begin
                            state_reg <= (pc_used_reg == '0) ? S_KBLK : S_KRD;
                        end
                    end
                    else if (bscan_reg == '0)
                    begin
                        res_reg.status <= ST_UNKNOWN_BLOCK;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        bscan_reg <= bscan_reg - BLK_CW'(1);
                        state_reg <= S_BRD;
                    end
                end
                S_CARVE1:
                begin
                    diff_reg  <= {1'b0, bent_reg.limit} - {1'b0, bent_reg.cursor};
                    state_reg <= S_CARVE2;
                end
                S_CARVE2:
                begin
                    state_reg <= S_DONE;
                    if (size_reg == '0 || size_reg[ALIGN_BITS-1:0] != '0 || diff_reg[ADDR_W]
                        || ADDR_W'(size_reg) > diff_reg[ADDR_W-1:0])
                    begin
                        res_reg.status <= ST_BAD_SIZE;
                    end
                    else if (pc_used_reg >= PC_LW'(MAX_PIECES))
                    begin
                        res_reg.status <= ST_PIECES_FULL;
                    end
                    else
                    begin
                        pc_we_reg              <= 1'b1;
                        pc_waddr_reg           <= pc_used_reg[PC_IW-1:0];
                        pc_wdata_reg.onlist    <= 1'b0;
                        pc_wdata_reg.alive     <= 1'b1;
                        pc_wdata_reg.link      <= LINK_NONE;
                        pc_wdata_reg.owner     <= bidx_reg;
                        pc_wdata_reg.addr      <= bent_reg.cursor;
                        pc_used_reg            <= pc_used_reg + PC_LW'(1);
                        blk_we_reg             <= 1'b1;
                        blk_waddr_reg          <= bidx_reg;
                        blk_wdata_reg          <= {bent_reg.alive, bent_reg.limit, carve_next,
                                                   bent_reg.base};
                        res_reg.result_addr    <= bent_reg.cursor;
                        res_reg.new_free_start <= carve_next;
                    end
                end
                S_PRD:
                begin
                    state_reg <= S_PCK;
                end
                S_PCK:
                begin
                    if (pc_rdata.alive && pc_rdata.addr == naddr_reg)
                    begin
                        pidx_reg <= pscan_reg[PC_IW-1:0];
                        pent_reg <= pc_rdata;
                        if (pc_rdata.onlist)
                        begin
                            res_reg.status <= ST_ALREADY_FILED;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            lscan_reg <= '0;
                            state_reg <= (ls_used_reg == '0) ? S_LNEW : S_LRD;
                        end
                    end
                    else if (pscan_reg == '0)
                    begin
                        res_reg.status <= ST_UNKNOWN_NODE;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        pscan_reg <= pscan_reg - PC_LW'(1);
                        state_reg <= S_PRD;
                    end
                end
                S_LRD:
                begin
                    state_reg <= S_LCK;
                end
                S_LCK:
                begin
                    if (ls_rdata.addr == laddr_reg)
                    begin
                        lidx_reg  <= lscan_reg[LS_IW-1:0];
                        lhead_reg <= ls_rdata.head;
                        lnew_reg  <= 1'b0;
                        state_reg <= S_LDONE;
                    end
                    else if (lscan_last)
                    begin
                        state_reg <= S_LNEW;
                    end
                    else
                    begin
                        lscan_reg <= lscan_reg + LS_CW'(1);
                        state_reg <= S_LRD;
                    end
                end
                S_LNEW:
                begin
                    if (ls_used_reg >= LS_CW'(MAX_LISTS))
                    begin
                        res_reg.status <= ST_LISTS_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        lidx_reg  <= ls_used_reg[LS_IW-1:0];
                        lhead_reg <= LINK_NONE;
                        lnew_reg  <= 1'b1;
                        state_reg <= S_LDONE;
                    end
                end
                S_LDONE:
                begin
                    if (kind_reg == REQ_FILE)
                    begin
                        pc_we_reg         <= 1'b1;
                        pc_waddr_reg      <= pidx_reg;
                        pc_wdata_reg      <= {1'b1, pent_reg.alive, lhead_reg, pent_reg.owner,
                                              pent_reg.addr};
                        ls_we_reg         <= 1'b1;
                        ls_waddr_reg      <= lidx_reg;
                        ls_wdata_reg.head <= PC_LW'(pidx_reg);
                        ls_wdata_reg.addr <= laddr_reg;
                        if (lnew_reg)
                        begin
                            ls_used_reg <= ls_used_reg + LS_CW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                    else if (lhead_reg >= LINK_NONE)
                    begin
                        res_reg.status <= ST_LIST_EMPTY;
                        if (lnew_reg)
                        begin
                            ls_we_reg         <= 1'b1;
                            ls_waddr_reg      <= lidx_reg;
                            ls_wdata_reg.head <= LINK_NONE;
                            ls_wdata_reg.addr <= laddr_reg;
                            ls_used_reg       <= ls_used_reg + LS_CW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_RRD;
                    end
                end
                S_RRD:
                begin
                    state_reg <= S_RCK;
                end
                S_RCK:
                begin
                    ls_we_reg           <= 1'b1;
                    ls_waddr_reg        <= lidx_reg;
                    ls_wdata_reg.head   <= pc_rdata.link;
                    ls_wdata_reg.addr   <= laddr_reg;
                    pc_we_reg           <= 1'b1;
                    pc_waddr_reg        <= lhead_reg[PC_IW-1:0];
                    pc_wdata_reg        <= {1'b0, pc_rdata.alive, LINK_NONE, pc_rdata.owner,
                                            pc_rdata.addr};
                    res_reg.result_addr <= pc_rdata.addr;
                    bidx_reg            <= pc_rdata.owner;
                    state_reg           <= S_ORD;
                end
                S_ORD:
                begin
                    state_reg <= S_OCK;
                end
                S_OCK:
                begin
                    res_reg.owner_block_addr <= blk_rdata.base;
                    state_reg                <= S_DONE;
                end
                S_KRD:
                begin
                    state_reg <= S_KCK;
                end
                S_KCK:
                begin
                    if (pc_rdata.alive && pc_rdata.owner == bidx_reg)
                    begin
                        pc_we_reg    <= 1'b1;
                        pc_waddr_reg <= pscan_reg[PC_IW-1:0];
                        pc_wdata_reg <= {pc_rdata.onlist, 1'b0, pc_rdata.link, pc_rdata.owner,
                                         pc_rdata.addr};
                    end
                    if ((pscan_reg + PC_LW'(1)) == pc_used_reg)
                    begin
                        state_reg <= S_KBLK;
                    end
                    else
                    begin
                        pscan_reg <= pscan_reg + PC_LW'(1);
                        state_reg <= S_KRD;
                    end
                end
                S_KBLK:
                begin
                    blk_we_reg    <= 1'b1;
                    blk_waddr_reg <= bidx_reg;
                    blk_wdata_reg <= {1'b0, bent_reg.limit, bent_reg.cursor, bent_reg.base};
                    lscan_reg     <= '0;
                    state_reg     <= (ls_used_reg == '0) ? S_DONE : S_URD;
                end
                S_URD:
                begin
                    state_reg <= S_UCK;
                end
                S_UCK:
                begin
                    lent_reg      <= ls_rdata;
                    cur_reg       <= ls_rdata.head;
                    prev_head_reg <= 1'b1;
                    if (ls_rdata.head < LINK_NONE)
                    begin
                        state_reg <= S_WRD;
                    end
                    else if (lscan_last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        lscan_reg <= lscan_reg + LS_CW'(1);
                        state_reg <= S_URD;
                    end
                end
                S_WRD:
                begin
                    state_reg <= S_WCK;
                end
                S_WCK:
                begin
                    if (!pc_rdata.alive)
                    begin
                        if (prev_head_reg)
                        begin
                            ls_we_reg         <= 1'b1;
                            ls_waddr_reg      <= lscan_reg[LS_IW-1:0];
                            ls_wdata_reg.head <= pc_rdata.link;
                            ls_wdata_reg.addr <= lent_reg.addr;
                            lent_reg.head     <= pc_rdata.link;
                        end
                        else
                        begin
                            pc_we_reg         <= 1'b1;
                            pc_waddr_reg      <= prev_idx_reg;
                            pc_wdata_reg      <= {prev_ent_reg.onlist, prev_ent_reg.alive,
                                                  pc_rdata.link, prev_ent_reg.owner,
                                                  prev_ent_reg.addr};
                            prev_ent_reg.link <= pc_rdata.link;
                        end
                    end
                    else
                    begin
                        prev_head_reg <= 1'b0;
                        prev_idx_reg  <= cur_reg[PC_IW-1:0];
                        prev_ent_reg  <= pc_rdata;
                    end
                    cur_reg <= pc_rdata.link;
                    if (pc_rdata.link < LINK_NONE)
                    begin
                        state_reg <= S_WRD;
                    end
                    else if (lscan_last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        lscan_reg <= lscan_reg + LS_CW'(1);
                        state_reg <= S_URD;
                    end
                end
                S_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // fill counts stay within their tables
    a_blk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        blk_used_reg <= BLK_CW'(MAX_BLOCKS))
        else $error("block count overflow");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_used_reg <= PC_LW'(MAX_PIECES))
        else $error("piece count overflow");

    a_ls_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ls_used_reg <= LS_CW'(MAX_LISTS))
        else $error("list count overflow");

    // slots are only ever appended one at a time
    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_used_reg != $past(pc_used_reg)) |-> (pc_used_reg == $past(pc_used_reg) + PC_LW'(1)))
        else $error("piece count jumped");

    // a finished request leaves through the output register before the next word
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_ready) |=> (state_reg == S_IDLE))
        else $error("result not handed off");

endmodule
`default_nettype wire

>>> design/bcf_ram.sv
`default_nettype none
module bcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> design/bcf_out.sv
`default_nettype none
module bcf_out (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire bcf_pkg::result_t                 in_res,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // result_addr, owner_block_addr, new_free_start
    output logic [bcf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // status
    output logic [3:0]                            m_axis_tuser
);
    import bcf_pkg::*;

    logic    full_reg;
    result_t data_reg;

    assign in_ready      = !full_reg || m_axis_tready;
    assign m_axis_tvalid = full_reg;
    assign m_axis_tdata  = {data_reg.new_free_start, data_reg.owner_block_addr,
                            data_reg.result_addr};
    assign m_axis_tuser  = data_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_res;
        end
    end

endmodule
`default_nettype wire

>>> sim/block_carve_freelist_engine_tb.sv
`default_nettype none
module block_carve_freelist_engine_tb;
    import bcf_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] fav;
        logic [ADDR_W-1:0] bend;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] lst;
        logic [ADDR_W-1:0] node;
    } alloc_req_t;

    typedef struct {
        status_t           st;
        logic [ADDR_W-1:0] res;
        logic [ADDR_W-1:0] own;
        logic [ADDR_W-1:0] nfa;
    } alloc_resp_t;

    localparam int IDLE_LIMIT = 30000;
    localparam int BIG_ROOM   = 32'h0010_0000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;

    block_carve_freelist_engine dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // shadow allocator tables
    logic [ADDR_W-1:0] sh_blk_base [MAX_BLOCKS];
    logic [ADDR_W-1:0] sh_blk_cur [MAX_BLOCKS];
    logic [ADDR_W-1:0] sh_blk_lim [MAX_BLOCKS];
    bit sh_blk_alive [MAX_BLOCKS];
    int sh_blk_n;
    logic [ADDR_W-1:0] sh_pc_addr [MAX_PIECES];
    int sh_pc_owner [MAX_PIECES];
    int sh_pc_link [MAX_PIECES];
    bit sh_pc_alive [MAX_PIECES];
    bit sh_pc_onlist [MAX_PIECES];
    int sh_pc_n;
    logic [ADDR_W-1:0] sh_ls_addr [MAX_LISTS];
    int sh_ls_head [MAX_LISTS];
    int sh_ls_n;

    alloc_req_t pending_reqs[$];
    alloc_resp_t expected_resps[$];
    alloc_req_t cur_req;
    int errors;
    int words_in;
    int gap_left;
    int burst_left;
    int hold_left;
    int rx_mode;
    int rx_cycle;
    bit long_hold_done;
    int idle_cycles;

    logic [ADDR_W-1:0] big_blk;
    logic [ADDR_W-1:0] blk_pool [8];
    logic [ADDR_W-1:0] list_pool [6];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int find_live_block(logic [ADDR_W-1:0] a);
        for (int i = sh_blk_n - 1; i >= 0; i--)
            if (sh_blk_alive[i] && sh_blk_base[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int find_live_piece(logic [ADDR_W-1:0] a);
        for (int i = sh_pc_n - 1; i >= 0; i--)
            if (sh_pc_alive[i] && sh_pc_addr[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int open_list(logic [ADDR_W-1:0] a);
        for (int i = 0; i < sh_ls_n; i++)
            if (sh_ls_addr[i] == a)
                return i;
        if (sh_ls_n >= MAX_LISTS)
            return -1;
        sh_ls_addr[sh_ls_n] = a;
        sh_ls_head[sh_ls_n] = MAX_PIECES;
        sh_ls_n++;
        return sh_ls_n - 1;
    endfunction

    function automatic void drop_dead_pieces();
        int prev;
        int c;
        int steps;
        for (int l = 0; l < sh_ls_n; l++) begin
            prev = -1;
            c = sh_ls_head[l];
            steps = 0;
            while (c < MAX_PIECES && steps < MAX_PIECES) begin
                steps++;
                if (!sh_pc_alive[c]) begin
                    if (prev < 0)
                        sh_ls_head[l] = sh_pc_link[c];
                    else
                        sh_pc_link[prev] = sh_pc_link[c];
                    c = sh_pc_link[c];
                end
                else begin
                    prev = c;
                    c = sh_pc_link[c];
                end
            end
        end
    endfunction

    function automatic alloc_resp_t allocate(alloc_req_t r);
        alloc_resp_t o;
        int b;
        int p;
        int l;
        o.st = ST_OK;
        o.res = '0;
        o.own = '0;
        o.nfa = '0;
        case (r.kind)
            REQ_LEND: begin
                if (sh_blk_n >= MAX_BLOCKS)
                    o.st = ST_BLOCKS_FULL;
                else if ({1'b0, r.fav} != {1'b0, r.blk} + (ADDR_W+1)'(HEADER_BYTES)
                         || r.bend <= r.fav)
                    o.st = ST_BAD_HEADER;
                else begin
                    sh_blk_base[sh_blk_n] = r.blk;
                    sh_blk_cur[sh_blk_n] = r.fav;
                    sh_blk_lim[sh_blk_n] = r.bend;
                    sh_blk_alive[sh_blk_n] = 1'b1;
                    sh_blk_n++;
                    o.res = r.blk;
                end
            end
            REQ_CARVE: begin
                b = find_live_block(r.blk);
                if (b < 0)
                    o.st = ST_UNKNOWN_BLOCK;
                else if (r.size == 0 || r.size[ALIGN_BITS-1:0] != 0
                         || sh_blk_lim[b] < sh_blk_cur[b]
                         || ADDR_W'(r.size) > sh_blk_lim[b] - sh_blk_cur[b])
                    o.st = ST_BAD_SIZE;
                else if (sh_pc_n >= MAX_PIECES)
                    o.st = ST_PIECES_FULL;
                else begin
                    sh_pc_addr[sh_pc_n] = sh_blk_cur[b];
                    sh_pc_owner[sh_pc_n] = b;
                    sh_pc_link[sh_pc_n] = MAX_PIECES;
                    sh_pc_alive[sh_pc_n] = 1'b1;
                    sh_pc_onlist[sh_pc_n] = 1'b0;
                    sh_pc_n++;
                    o.res = sh_blk_cur[b];
                    sh_blk_cur[b] = sh_blk_cur[b] + ADDR_W'(r.size);
                    o.nfa = sh_blk_cur[b];
                end
            end
            REQ_FILE: begin
                p = find_live_piece(r.node);
                if (p < 0)
                    o.st = ST_UNKNOWN_NODE;
                else if (sh_pc_onlist[p])
                    o.st = ST_ALREADY_FILED;
                else begin
                    l = open_list(r.lst);
                    if (l < 0)
                        o.st = ST_LISTS_FULL;
                    else begin
                        sh_pc_onlist[p] = 1'b1;
                        sh_pc_link[p] = sh_ls_head[l];
                        sh_ls_head[l] = p;
                    end
                end
            end
            REQ_REISSUE: begin
                l = open_list(r.lst);
                if (l < 0)
                    o.st = ST_LISTS_FULL;
                else if (sh_ls_head[l] >= MAX_PIECES)
                    o.st = ST_LIST_EMPTY;
                else begin
                    p = sh_ls_head[l];
                    sh_ls_head[l] = sh_pc_link[p];
                    sh_pc_link[p] = MAX_PIECES;
                    sh_pc_onlist[p] = 1'b0;
                    o.res = sh_pc_addr[p];
                    o.own = sh_blk_base[sh_pc_owner[p]];
                end
            end
            REQ_RETURN: begin
                b = find_live_block(r.blk);
                if (b < 0)
                    o.st = ST_UNKNOWN_BLOCK;
                else begin
                    for (int i = 0; i < sh_pc_n; i++)
                        if (sh_pc_alive[i] && sh_pc_owner[i] == b)
                            sh_pc_alive[i] = 1'b0;
                    sh_blk_alive[b] = 1'b0;
                    drop_dead_pieces();
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [ADDR_W-1:0] pool_addr();
        return {12'($urandom), 32'($urandom), 4'h0};
    endfunction

    task automatic push(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] f,
                        logic [ADDR_W-1:0] e, logic [SIZE_W-1:0] s, logic [ADDR_W-1:0] l,
                        logic [ADDR_W-1:0] n);
        alloc_req_t r;
        r.kind = k;
        r.blk = b;
        r.fav = f;
        r.bend = e;
        r.size = s;
        r.lst = l;
        r.node = n;
        pending_reqs.push_back(r);
    endtask

    task automatic push_lend(logic [ADDR_W-1:0] b, int room);
        push(REQ_LEND, b, b + HEADER_BYTES, b + HEADER_BYTES + room, '0, rand_addr(), rand_addr());
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            gap_left = 0;
            burst_left = 4;
            words_in = 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_resps.push_back(allocate(cur_req));
                words_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata <= {2'b00, cur_req.node, cur_req.lst, cur_req.size,
                                     cur_req.bend, cur_req.fav, cur_req.blk};
                    s_axis_tuser <= cur_req.kind;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern chosen at random among four modes, one long hold-off
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            rx_mode = 0;
            rx_cycle = 0;
            long_hold_done = 1'b0;
        end
        else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            if (!long_hold_done && words_in >= 120) begin
                long_hold_done = 1'b1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // result checker and watchdog
    always @(posedge clk) begin
        alloc_resp_t e;
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_resps.size() == 0) begin
                    $display("%0t unexpected word status %0d data %h", $time, m_axis_tuser,
                             m_axis_tdata);
                    errors++;
                end
                else begin
                    e = expected_resps.pop_front();
                    if (m_axis_tuser != e.st) begin
                        $display("%0t status exp %0d got %0d", $time, e.st, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[ADDR_W-1:0] != e.res) begin
                        $display("%0t result_addr exp %h got %h", $time, e.res,
                                 m_axis_tdata[ADDR_W-1:0]);
                        errors++;
                    end
                    if (m_axis_tdata[2*ADDR_W-1:ADDR_W] != e.own) begin
                        $display("%0t owner_block_addr exp %h got %h", $time, e.own,
                                 m_axis_tdata[2*ADDR_W-1:ADDR_W]);
                        errors++;
                    end
                    if (m_axis_tdata[3*ADDR_W-1:2*ADDR_W] != e.nfa) begin
                        $display("%0t new_free_start exp %h got %h", $time, e.nfa,
                                 m_axis_tdata[3*ADDR_W-1:2*ADDR_W]);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t timeout, %0d words outstanding", $time, expected_resps.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] tmp_blk;
        int sel;
        errors = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        big_blk = pool_addr();
        for (int i = 0; i < 8; i++)
            blk_pool[i] = pool_addr();
        for (int i = 0; i < 6; i++)
            list_pool[i] = rand_addr();
        tmp_blk = pool_addr();

        // directed
        push_lend(big_blk, BIG_ROOM);
        push(REQ_LEND, tmp_blk, tmp_blk + 48, tmp_blk + 200, '0, '0, '0);
        push(REQ_LEND, tmp_blk, tmp_blk + HEADER_BYTES, tmp_blk + HEADER_BYTES, '0, '0, '0);
        push(REQ_LEND, 48'hFFFF_FFFF_FFF0, 48'h0000_0000_0018, 48'hFFFF_FFFF_FFFF,
             '1, '1, '1);
        push(REQ_CARVE, tmp_blk, '0, '0, 14'd16, '0, '0);
        push(REQ_CARVE, big_blk, '0, '0, 14'd0, '0, '0);
        push(REQ_CARVE, big_blk, '0, '0, 14'd8, '0, '0);
        push(REQ_CARVE, big_blk, '0, '0, 14'd16, '0, '0);
        push(REQ_CARVE, big_blk, '0, '0, 14'd8192, '0, '0);
        push_lend(tmp_blk, 64);
        push(REQ_CARVE, tmp_blk, '0, '0, 14'd8192, '0, '0);
        push(REQ_CARVE, tmp_blk, '0, '0, 14'd64, '0, '0);
        push(REQ_FILE, '0, '0, '0, '0, list_pool[0], big_blk + 8);
        push(REQ_FILE, '0, '0, '0, '0, list_pool[0], big_blk + HEADER_BYTES);
        push(REQ_FILE, '0, '0, '0, '0, list_pool[1], big_blk + HEADER_BYTES);
        push(REQ_FILE, '0, '0, '0, '0, list_pool[1], tmp_blk + HEADER_BYTES);
        push(REQ_REISSUE, '0, '0, '0, '0, list_pool[0], '0);
        push(REQ_REISSUE, '0, '0, '0, '0, list_pool[0], '0);
        push(REQ_REISSUE, '0, '0, '0, '0, list_pool[2], '0);
        push(REQ_RETURN, tmp_blk + 16, '0, '0, '0, '0, '0);
        push(REQ_RETURN, tmp_blk, '0, '0, '0, '0, '0);
        push(REQ_REISSUE, '0, '0, '0, '0, list_pool[1], '0);
        push(3'd5, '1, '1, '1, '1, '1, '1);
        push(3'd6, rand_addr(), rand_addr(), rand_addr(), 14'($urandom), rand_addr(), '0);
        push(3'd7, '0, '0, '0, '0, '0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // random mix, mostly well-formed on a small set of blocks and lists
        for (int n = 0; n < 400; n++) begin
            sel = $urandom_range(0, 99);
            b = blk_pool[$urandom_range(0, 7)];
            if (sel < 7)
                push_lend(b, 16 * $urandom_range(1, 64));
            else if (sel < 10)
                push(REQ_LEND, b, b + HEADER_BYTES + $urandom_range(0, 1) * 16,
                     b + $urandom_range(0, 80), '0, '0, '0);
            else if (sel < 38)
                push(REQ_CARVE, b, '0, '0,
                     ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'(16 * $urandom_range(1, 4)),
                     '0, '0);
            else if (sel < 58)
                push(REQ_FILE, '0, '0, '0, '0, list_pool[$urandom_range(0, 5)],
                     b + HEADER_BYTES + 16 * $urandom_range(0, 12));
            else if (sel < 75)
                push(REQ_REISSUE, '0, '0, '0, '0, list_pool[$urandom_range(0, 5)], '0);
            else if (sel < 80)
                push(REQ_RETURN, b, '0, '0, '0, '0, '0);
            else
                push(3'($urandom_range(0, 7)), rand_addr(), rand_addr(), rand_addr(),
                     14'($urandom), rand_addr(), rand_addr());
        end
        drain();

        // fill the list and block tables to their limits
        for (int n = 0; n < 17; n++)
            push(REQ_REISSUE, '0, '0, '0, '0, rand_addr(), '0);
        push(REQ_FILE, '0, '0, '0, '0, rand_addr(), big_blk + HEADER_BYTES + 16);
        for (int n = 0; n < 66; n++)
            push_lend(pool_addr(), 4096);
        for (int n = 0; n < 40; n++)
            push(REQ_CARVE, big_blk, '0, '0, 14'd16, '0, '0);
        push(REQ_RETURN, big_blk, '0, '0, '0, '0, '0);
        push(REQ_REISSUE, '0, '0, '0, '0, list_pool[0], '0);

        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

>>> block_carve_freelist_engine.f
design/bcf_pkg.sv
design/bcf_ram.sv
design/bcf_out.sv
design/block_carve_freelist_engine.sv
sim/block_carve_freelist_engine_tb.sv
